@@ rtl/sli_pkg.sv @@
// sli_pkg: shared types, codes and elaboration-time helpers for the ordered list
// covers the transaction payloads, status and function codes, the cell control word
// and the sizing of the registered read-out tree; depends on nothing
package sli_pkg;

  localparam int CAPACITY_DEF   = 64;
  localparam int ELEM_WIDTH_DEF = 32;
  localparam int IDX_MAX_W      = 10;
  localparam int FAN_IN         = 8;
  localparam int FAN_LOG        = 3;

  typedef enum logic [2:0] {
    FN_INS_FRONT = 3'd0,
    FN_INS_END   = 3'd1,
    FN_INS_POS   = 3'd2,
    FN_REM_FRONT = 3'd3,
    FN_REM_END   = 3'd4,
    FN_REM_POS   = 3'd5
  } func_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    OP_NONE = 2'd0,
    OP_INS  = 2'd1,
    OP_REM  = 2'd2
  } op_t;

  typedef struct packed {
    logic [2:0]  func;
    logic [5:0]  position;
    logic [31:0] item_value;
  } in_item_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] removed_value;
    logic [6:0]  entry_total;
  } out_item_t;

  typedef struct packed {
    op_t                  op;
    logic [IDX_MAX_W-1:0] at;
  } cell_ctl_t;

  // node count of read-out tree level l (level 0 is the cell taps)
  function automatic int lvl_size(input int cap, input int l);
    int n;
    n = cap;
    for (int i = 0; i < l; i++) begin
      n = (n + FAN_IN - 1) >> FAN_LOG;
    end
    return n;
  endfunction

  function automatic int tree_levels(input int cap);
    int n;
    int lv;
    n  = cap;
    lv = 1;
    while (n > 1) begin
      n  = (n + FAN_IN - 1) >> FAN_LOG;
      lv = lv + 1;
    end
    return lv;
  endfunction

  // offset of level l (l >= 1) in the flat register array of the tree
  function automatic int lvl_off(input int cap, input int l);
    int s;
    s = 0;
    for (int k = 1; k < l; k++) begin
      s = s + lvl_size(cap, k);
    end
    return s;
  endfunction

endpackage

@@ rtl/sli_cell.sv @@
// sli_cell: one list slot, shifting with its neighbours on insert and remove
// depends on sli_pkg for the cell control word
module sli_cell #(
  parameter int ELEM_WIDTH = sli_pkg::ELEM_WIDTH_DEF,
  parameter int INDEX      = 0
) (
  input  logic                  clk,
  input  sli_pkg::cell_ctl_t    ctl_i,
  input  logic [ELEM_WIDTH-1:0] ins_word_i,
  input  logic [ELEM_WIDTH-1:0] prev_i,
  input  logic [ELEM_WIDTH-1:0] next_i,
  output logic [ELEM_WIDTH-1:0] data_o,
  output logic [ELEM_WIDTH-1:0] tap_o
);

  localparam logic [sli_pkg::IDX_MAX_W-1:0] MY_IDX = sli_pkg::IDX_MAX_W'(INDEX);

  logic [ELEM_WIDTH-1:0] data_r;
  logic [ELEM_WIDTH-1:0] tap_r;
  logic                  is_at;
  logic                  above;

  assign is_at = (ctl_i.at == MY_IDX);
  assign above = (MY_IDX > ctl_i.at);

  always_ff @(posedge clk) begin
    unique case (ctl_i.op)
      sli_pkg::OP_INS: begin
        if (above) begin
          data_r <= prev_i;
        end else if (is_at) begin
          data_r <= ins_word_i;
        end
      end
      sli_pkg::OP_REM: begin
        if (above || is_at) begin
          data_r <= next_i;
        end
      end
      default: begin
      end
    endcase
    if (ctl_i.op != sli_pkg::OP_NONE) begin
      tap_r <= (ctl_i.op == sli_pkg::OP_REM && is_at) ? data_r : '0;
    end
  end

  assign data_o = data_r;
  assign tap_o  = tap_r;

endmodule

@@ rtl/sli_tree.sv @@
// sli_tree: registered or-reduction of the cell taps, one tree level per cycle
// depends on sli_pkg for fan-in and level sizing
module sli_tree #(
  parameter int CAPACITY   = sli_pkg::CAPACITY_DEF,
  parameter int ELEM_WIDTH = sli_pkg::ELEM_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic [ELEM_WIDTH-1:0] taps_i [CAPACITY],
  output logic [ELEM_WIDTH-1:0] root_o
);

  localparam int NLVL  = sli_pkg::tree_levels(CAPACITY);
  localparam int TOTAL = sli_pkg::lvl_off(CAPACITY, NLVL);

  logic [ELEM_WIDTH-1:0] node_r [TOTAL];

  for (genvar l = 1; l < NLVL; l++) begin : g_lvl
    localparam int NP    = sli_pkg::lvl_size(CAPACITY, l - 1);
    localparam int NC    = sli_pkg::lvl_size(CAPACITY, l);
    localparam int C_OFF = sli_pkg::lvl_off(CAPACITY, l);
    for (genvar j = 0; j < NC; j++) begin : g_node
      localparam int BASE = j * sli_pkg::FAN_IN;
      localparam int KIDS = (NP - BASE < sli_pkg::FAN_IN) ? NP - BASE : sli_pkg::FAN_IN;
      logic [ELEM_WIDTH-1:0] acc;
      if (l == 1) begin : g_leaf
        always_comb begin
          acc = '0;
          for (int c = 0; c < KIDS; c++) begin
            acc = acc | taps_i[BASE + c];
          end
        end
      end else begin : g_inner
        localparam int P_OFF = sli_pkg::lvl_off(CAPACITY, l - 1);
        always_comb begin
          acc = '0;
          for (int c = 0; c < KIDS; c++) begin
            acc = acc | node_r[P_OFF + BASE + c];
          end
        end
      end
      always_ff @(posedge clk) begin
        node_r[C_OFF + j] <= acc;
      end
    end
  end

  assign root_o = node_r[TOTAL-1];

endmodule

@@ rtl/sequential_list_insert_remove.sv @@
// result path: cell tap registers, registered 8-way tree that reads out the removed word, then
// the out_data register; NLVL = 1 + ceil(log8(CAPACITY)) tree levels are waited out in S_DRAIN
// one transaction in flight: a new one is accepted only after out_ready has taken the result
// all cells shift in the accept cycle; in_ready is low until the result is taken
// reset (rst_n, synchronous, active low) empties the list; entry contents are not cleared
// depends on sli_pkg, sli_cell and sli_tree
module sequential_list_insert_remove #(
  parameter int CAPACITY   = sli_pkg::CAPACITY_DEF,
  parameter int ELEM_WIDTH = sli_pkg::ELEM_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  sli_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output sli_pkg::out_item_t out_data
);

  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int CMP_W  = (CNT_W > 6) ? CNT_W : 6;
  localparam int NLVL   = sli_pkg::tree_levels(CAPACITY);
  localparam int WAIT_W = $clog2(NLVL);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DRAIN,
    S_DONE
  } state_t;

  state_t                  state_r;
  logic [CNT_W-1:0]        count_r;
  logic [CNT_W-1:0]        count_nxt;
  logic [WAIT_W-1:0]       wait_r;
  sli_pkg::status_t        status_r;
  sli_pkg::status_t        status_nxt;
  logic                    rem_ok_r;
  sli_pkg::out_item_t      out_data_r;
  sli_pkg::cell_ctl_t      ctl;
  sli_pkg::op_t            op_dec;
  logic [sli_pkg::IDX_MAX_W-1:0] at_dec;
  logic                    accept;
  logic                    full;
  logic                    empty;
  logic [CMP_W-1:0]        pos_ext;
  logic [CMP_W-1:0]        cnt_ext;
  logic [ELEM_WIDTH+31:0]  ins_wide;
  logic [ELEM_WIDTH-1:0]   ins_word;
  logic [ELEM_WIDTH+31:0]  rem_wide;
  logic [CNT_W+6:0]        tot_wide;
  logic [ELEM_WIDTH-1:0]   root;
  logic [ELEM_WIDTH-1:0]   cell_data [CAPACITY];
  logic [ELEM_WIDTH-1:0]   cell_tap  [CAPACITY];

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_DONE);
  assign out_data  = out_data_r;
  assign accept    = in_valid && in_ready;

  assign full    = (count_r == CNT_W'(CAPACITY));
  assign empty   = (count_r == '0);
  assign pos_ext = CMP_W'(in_data.position);
  assign cnt_ext = CMP_W'(count_r);

  assign ins_wide = {{ELEM_WIDTH{1'b0}}, in_data.item_value};
  assign ins_word = ins_wide[ELEM_WIDTH-1:0];
  assign rem_wide = {32'b0, root};
  assign tot_wide = {7'b0, count_r};

  always_comb begin
    status_nxt = sli_pkg::ST_OK;
    op_dec     = sli_pkg::OP_NONE;
    at_dec     = '0;
    unique case (in_data.func)
      sli_pkg::FN_INS_FRONT: begin
        if (full) begin
          status_nxt = sli_pkg::ST_FULL;
        end else begin
          op_dec = sli_pkg::OP_INS;
        end
      end
      sli_pkg::FN_INS_END: begin
        if (full) begin
          status_nxt = sli_pkg::ST_FULL;
        end else begin
          op_dec = sli_pkg::OP_INS;
          at_dec = sli_pkg::IDX_MAX_W'(count_r);
        end
      end
      sli_pkg::FN_INS_POS: begin
        if (full) begin
          status_nxt = sli_pkg::ST_FULL;
        end else if (pos_ext > cnt_ext) begin
          status_nxt = sli_pkg::ST_RANGE;
        end else begin
          op_dec = sli_pkg::OP_INS;
          at_dec = sli_pkg::IDX_MAX_W'(in_data.position);
        end
      end
      sli_pkg::FN_REM_FRONT: begin
        if (empty) begin
          status_nxt = sli_pkg::ST_EMPTY;
        end else begin
          op_dec = sli_pkg::OP_REM;
        end
      end
      sli_pkg::FN_REM_END: begin
        if (empty) begin
          status_nxt = sli_pkg::ST_EMPTY;
        end else begin
          op_dec = sli_pkg::OP_REM;
          at_dec = sli_pkg::IDX_MAX_W'(count_r - CNT_W'(1));
        end
      end
      sli_pkg::FN_REM_POS: begin
        if (empty) begin
          status_nxt = sli_pkg::ST_EMPTY;
        end else if (pos_ext >= cnt_ext) begin
          status_nxt = sli_pkg::ST_RANGE;
        end else begin
          op_dec = sli_pkg::OP_REM;
          at_dec = sli_pkg::IDX_MAX_W'(in_data.position);
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    ctl.op = accept ? op_dec : sli_pkg::OP_NONE;
    ctl.at = at_dec;
    unique case (ctl.op)
      sli_pkg::OP_INS: count_nxt = count_r + CNT_W'(1);
      sli_pkg::OP_REM: count_nxt = count_r - CNT_W'(1);
      default:         count_nxt = count_r;
    endcase
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [ELEM_WIDTH-1:0] prev;
    logic [ELEM_WIDTH-1:0] next;
    if (i == 0) begin : g_head
      assign prev = cell_data[i];
    end else begin : g_body
      assign prev = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign next = cell_data[i];
    end else begin : g_link
      assign next = cell_data[i+1];
    end
    sli_cell #(
      .ELEM_WIDTH (ELEM_WIDTH),
      .INDEX      (i)
    ) u_cell (
      .clk        (clk),
      .ctl_i      (ctl),
      .ins_word_i (ins_word),
      .prev_i     (prev),
      .next_i     (next),
      .data_o     (cell_data[i]),
      .tap_o      (cell_tap[i])
    );
  end

  sli_tree #(
    .CAPACITY   (CAPACITY),
    .ELEM_WIDTH (ELEM_WIDTH)
  ) u_tree (
    .clk    (clk),
    .taps_i (cell_tap),
    .root_o (root)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            count_r  <= count_nxt;
            status_r <= status_nxt;
            rem_ok_r <= (op_dec == sli_pkg::OP_REM);
            wait_r   <= WAIT_W'(NLVL - 1);
            state_r  <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (wait_r == '0) begin
            out_data_r.status        <= status_r;
            out_data_r.removed_value <= rem_ok_r ? rem_wide[31:0] : 32'b0;
            out_data_r.entry_total   <= tot_wide[6:0];
            state_r                  <= S_DONE;
          end else begin
            wait_r <= wait_r - WAIT_W'(1);
          end
        end
        S_DONE: begin
          if (out_ready) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/sli_chk.sv @@
// sli_chk: port-level checks on the ordered list, bound to the top level
// depends on sli_pkg for the payload types and status codes
module sli_chk (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input sli_pkg::in_item_t  in_data,
  input logic               out_valid,
  input logic               out_ready,
  input sli_pkg::out_item_t out_data
);

  // one transaction in flight at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input ready while a result is pending");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input ready straight after a transaction");

  a_fail_no_word: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status != sli_pkg::ST_OK) |-> (out_data.removed_value == 32'b0))
    else $error("failed request returned a word");

  a_empty_total: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status == sli_pkg::ST_EMPTY) |-> (out_data.entry_total == 7'd0))
    else $error("empty status with entries held");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("result dropped or changed while stalled");

endmodule

bind sequential_list_insert_remove sli_chk u_sli_chk (.*);

@@ tb/tb.sv @@
// tb: self-checking testbench for sequential_list_insert_remove, the packed ordered list
// drives insert and remove transactions, predicts each result with an in-bench list model
// and checks every result field; depends on sli_pkg and the rtl top level only
`timescale 1ns / 1ps

module tb;

  localparam int CAP = sli_pkg::CAPACITY_DEF;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [2:0] FN_SPARE_6 = 3'd6;
  localparam logic [2:0] FN_SPARE_7 = 3'd7;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  sli_pkg::in_item_t  in_data = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  sli_pkg::out_item_t out_data;

  logic [31:0]        list_words [CAP];
  int                 list_len = 0;
  int                 peak_len = 0;
  sli_pkg::out_item_t pending_results [$];
  sli_pkg::out_item_t want_res;
  int                 idle_pct = 23;
  int                 err_cnt = 0;
  int                 sent = 0;
  int                 checked = 0;
  int                 seen_status [4];
  int                 cycles = 0;

  sequential_list_insert_remove u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               pending_results.size());
      $display("tb NOT OK");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= idle_pct);
  end

  // updates the list model and returns the result the transaction should give
  function automatic sli_pkg::out_item_t apply_list_op(input sli_pkg::in_item_t it);
    sli_pkg::out_item_t res;
    int                 at;
    res = '0;
    res.status = sli_pkg::ST_OK;
    at = 0;
    case (it.func)
      sli_pkg::FN_INS_FRONT, sli_pkg::FN_INS_END, sli_pkg::FN_INS_POS: begin
        if (it.func == sli_pkg::FN_INS_FRONT) at = 0;
        else if (it.func == sli_pkg::FN_INS_END) at = list_len;
        else at = it.position;
        if (list_len >= CAP) begin
          res.status = sli_pkg::ST_FULL;
        end else if (at > list_len) begin
          res.status = sli_pkg::ST_RANGE;
        end else begin
          for (int i = list_len; i > at; i--) list_words[i] = list_words[i-1];
          list_words[at] = it.item_value;
          list_len++;
        end
      end
      sli_pkg::FN_REM_FRONT, sli_pkg::FN_REM_END, sli_pkg::FN_REM_POS: begin
        if (it.func == sli_pkg::FN_REM_FRONT) at = 0;
        else if (it.func == sli_pkg::FN_REM_END) at = list_len - 1;
        else at = it.position;
        if (list_len == 0) begin
          res.status = sli_pkg::ST_EMPTY;
        end else if (at >= list_len) begin
          res.status = sli_pkg::ST_RANGE;
        end else begin
          res.removed_value = list_words[at];
          for (int i = at; i + 1 < list_len; i++) list_words[i] = list_words[i+1];
          list_len--;
        end
      end
      default: ;
    endcase
    res.entry_total = 7'(list_len);
    return res;
  endfunction

  function automatic sli_pkg::in_item_t mk(input logic [2:0] fn, input int pos,
                                           input logic [31:0] val);
    sli_pkg::in_item_t it;
    it.func = fn;
    it.position = 6'(pos);
    it.item_value = val;
    return it;
  endfunction

  // random transaction, mostly with a legal position for the current fill level
  function automatic sli_pkg::in_item_t rand_op(input int ins_pct);
    logic [2:0] fn;
    int         pos;
    if ($urandom_range(0, 99) < 3) begin
      fn = $urandom_range(0, 1) ? FN_SPARE_6 : FN_SPARE_7;
    end else if ($urandom_range(0, 99) < ins_pct) begin
      fn = 3'($urandom_range(sli_pkg::FN_INS_FRONT, sli_pkg::FN_INS_POS));
    end else begin
      fn = 3'($urandom_range(sli_pkg::FN_REM_FRONT, sli_pkg::FN_REM_POS));
    end
    if ($urandom_range(0, 99) < 12) pos = $urandom_range(0, 63);
    else if (fn == sli_pkg::FN_INS_POS) pos = $urandom_range(0, list_len < 63 ? list_len : 63);
    else if (list_len > 0) pos = $urandom_range(0, list_len - 1);
    else pos = $urandom_range(0, 63);
    return mk(fn, pos, $urandom);
  endfunction

  task automatic send_item(input sli_pkg::in_item_t it);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.push_back(apply_list_op(it));
    sent++;
    if (list_len > peak_len) peak_len = list_len;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10) $display("unexpected result: status %0d removed %h total %0d",
                                    out_data.status, out_data.removed_value,
                                    out_data.entry_total);
      end else begin
        want_res = pending_results.pop_front();
        checked++;
        seen_status[want_res.status]++;
        if (out_data.status !== want_res.status ||
            out_data.removed_value !== want_res.removed_value ||
            out_data.entry_total !== want_res.entry_total) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("mismatch %0d: exp st %0d rm %h tot %0d, got st %0d rm %h tot %0d",
                     checked, want_res.status, want_res.removed_value, want_res.entry_total,
                     out_data.status, out_data.removed_value, out_data.entry_total);
        end
      end
    end
  end

  // failed removes, spare codes and an out-of-range insert on an empty list
  task automatic test_empty_list();
    send_item(mk(sli_pkg::FN_REM_FRONT, 0, 32'h0));
    send_item(mk(sli_pkg::FN_REM_END, 0, 32'h0));
    send_item(mk(sli_pkg::FN_REM_POS, 0, 32'hFFFF_FFFF));
    send_item(mk(FN_SPARE_6, 63, 32'hFFFF_FFFF));
    send_item(mk(FN_SPARE_7, 0, 32'h0));
    send_item(mk(sli_pkg::FN_INS_POS, 1, 32'h1234_5678));
  endtask

  task automatic test_insert_kinds();
    send_item(mk(sli_pkg::FN_INS_FRONT, 63, 32'h0000_0000));
    send_item(mk(sli_pkg::FN_INS_END, 0, 32'hFFFF_FFFF));
    send_item(mk(sli_pkg::FN_INS_POS, 1, 32'hAAAA_5555));
    send_item(mk(sli_pkg::FN_INS_POS, 3, 32'h5555_AAAA));
    send_item(mk(sli_pkg::FN_INS_POS, 63, 32'h8000_0001));
    send_item(mk(sli_pkg::FN_INS_POS, 5, 32'h0F0F_F0F0));
    send_item(mk(FN_SPARE_7, 2, 32'hDEAD_BEEF));
  endtask

  task automatic test_remove_kinds();
    send_item(mk(sli_pkg::FN_REM_POS, 1, 32'h0));
    send_item(mk(sli_pkg::FN_REM_POS, 3, 32'h0));
    send_item(mk(sli_pkg::FN_REM_POS, 63, 32'h0));
    send_item(mk(sli_pkg::FN_REM_END, 0, 32'h0));
    send_item(mk(sli_pkg::FN_REM_FRONT, 0, 32'h0));
    send_item(mk(sli_pkg::FN_REM_FRONT, 0, 32'h0));
    send_item(mk(sli_pkg::FN_REM_END, 0, 32'h0));
  endtask

  // fill to capacity, push against full, drain to empty, push against empty
  task automatic test_fill_drain(input int rounds);
    for (int r = 0; r < rounds; r++) begin
      while (list_len < CAP) send_item(rand_op(92));
      repeat ($urandom_range(1, 3)) send_item(rand_op(100));
      while (list_len > 0) send_item(rand_op(8));
      repeat ($urandom_range(1, 3)) send_item(rand_op(0));
    end
  endtask

  task automatic test_random_mix(input int n);
    int ins_pct;
    for (int k = 0; k < n; k++) begin
      idle_pct = (k < 300) ? 0 : 23;
      if (list_len < 4) ins_pct = 75;
      else if (list_len > CAP - 4) ins_pct = 25;
      else ins_pct = 50;
      send_item(rand_op(ins_pct));
    end
    idle_pct = 23;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_list();
    test_insert_kinds();
    test_remove_kinds();
    test_fill_drain(5);
    test_random_mix(1250);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    err_cnt += pending_results.size();
    $display("%0d transactions sent, %0d results checked, peak fill %0d of %0d",
             sent, checked, peak_len, CAP);
    $display("status seen: ok %0d, full %0d, empty %0d, out of range %0d; errors %0d",
             seen_status[sli_pkg::ST_OK], seen_status[sli_pkg::ST_FULL],
             seen_status[sli_pkg::ST_EMPTY], seen_status[sli_pkg::ST_RANGE], err_cnt);
    if (err_cnt == 0) $display("tb OK");
    else $display("tb NOT OK");
    $finish;
  end

endmodule
